[sv/xxhash64_digest_defines.svh]
// Assertion macros used by the checker file
`ifndef XXHASH64_DIGEST_DEFINES_SVH
`define XXHASH64_DIGEST_DEFINES_SVH

// same-cycle implication
`define XXH_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("xxhash64 check failed");

// next-cycle implication
`define XXH_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("xxhash64 check failed");

`endif

[sv/xxh_pkg.sv]
// ----------------------------------------------------------------------------
// xxh_pkg
// Constants, sequencer steps and control structs of the XXH64 digest block.
// ----------------------------------------------------------------------------
package xxh_pkg;

	localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] P3 = 64'h165667B19E3779F9;
	localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LR1,
		ST_LR2,
		ST_HINIT,
		ST_MG1,
		ST_MG2,
		ST_MG3,
		ST_ADDLEN,
		ST_TAIL,
		ST_T81,
		ST_T82,
		ST_T83,
		ST_T41,
		ST_T42,
		ST_T11,
		ST_T12,
		ST_AV1,
		ST_AV2,
		ST_FIN
	} step_t;

	typedef struct packed {
		step_t      op;
		logic [1:0] idx;
		logic       load;
		logic       start;
		logic       wb;
	} cmd_t;

	typedef struct packed {
		logic fold_need;
		logic stripe_done;
		logic t8;
		logic t4;
		logic t1;
		logic mul_done;
	} sts_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

endpackage

[sv/xxhash64_digest.sv]
// ----------------------------------------------------------------------------
// xxhash64_digest
// Streaming XXH64 digest over little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with data_word, byte_count, last_word.
// A request is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with digest, one request per message.
// Seed: cfg_we writes cfg_data into the seed register; write while idle.
// Every 64-bit multiply runs on one shared 32x32 multiplier in three steps,
// between its issue and its write-back.
// A word that neither completes a stripe nor ends the message leaves the sequencer idle.
// A word that completes a 32-byte stripe adds eight multiplies, two for each
// of the four lane rounds.
// On the last word the merge (12 multiplies when a stripe was folded), the
// tail (3 per 8-byte, 2 per 4-byte, 2 per byte step) and the avalanche
// (2 multiplies) run before the digest is registered.
// The digest waits in its output register under out_stall; the next message
// can start meanwhile, and its digest holds until the first is taken.
// Reset clears the seed to zero and starts an empty message.
// ----------------------------------------------------------------------------
module xxhash64_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest
);

	xxh_pkg::cmd_t cmd;
	xxh_pkg::sts_t sts;

	xxh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_word (last_word),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	xxh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.cmd        (cmd),
		.sts        (sts),
		.digest     (digest)
	);

endmodule

[sv/xxh_mul.sv]
// ----------------------------------------------------------------------------
// xxh_mul
// 64x64 multiplier, low 64 bits, from one 32x32 multiplier: low product, then both cross terms.
// ----------------------------------------------------------------------------
module xxh_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);

	logic [63:0] a_q, b_q, p_q;
	logic [1:0]  stp_q;
	logic        busy_q, done_q;
	logic [31:0] ma, mb;
	logic [63:0] m;

	always_comb begin
		ma = (stp_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		mb = (stp_q == 2'd1) ? b_q[63:32] : b_q[31:0];
		m  = {32'd0, ma} * {32'd0, mb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			stp_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				stp_q  <= 2'd0;
			end else if (busy_q) begin
				stp_q <= stp_q + 2'd1;
				if (stp_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (stp_q == 2'd0) begin
				p_q <= m;
			end else begin
				p_q[63:32] <= p_q[63:32] + m[31:0];
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

[sv/xxh_dp.sv]
// ----------------------------------------------------------------------------
// xxh_dp
// Datapath: seed, lanes, stripe buffer, length, tail fold and avalanche.
// ----------------------------------------------------------------------------
module xxh_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [63:0]   cfg_data,
	input  logic [63:0]   data_word,
	input  logic [3:0]    byte_count,
	input  logic          last_word,
	input  xxh_pkg::cmd_t cmd,
	output xxh_pkg::sts_t sts,
	output logic [63:0]   digest
);

	logic [63:0] seed_q, len_q, h_q, t_q, dig_q;
	logic [63:0] buf_q  [4];
	logic [63:0] lane_q [4];
	logic [4:0]  fill_q, pos_q;
	logic        done_q;

	logic [3:0]  cnt;
	logic [63:0] mask, wordm, lsrc, tw, rsum, ma, mb, p;
	logic [5:0]  fill_sum;
	logic        mul_done;

	always_comb begin
		cnt = (!last_word || byte_count > 4'd8) ? 4'd8 : byte_count;
		if (cnt == 4'd8) begin
			mask = '1;
		end else begin
			mask = (64'd1 << {cnt[2:0], 3'b000}) - 64'd1;
		end
		wordm    = data_word & mask;
		fill_sum = {1'b0, fill_q} + {2'b00, cnt};
		case (cmd.idx)
			2'd0:    lsrc = seed_q + xxh_pkg::P1 + xxh_pkg::P2;
			2'd1:    lsrc = seed_q + xxh_pkg::P2;
			2'd2:    lsrc = seed_q;
			default: lsrc = seed_q - xxh_pkg::P1;
		endcase
		if (done_q) begin
			lsrc = lane_q[cmd.idx];
		end
		tw   = buf_q[pos_q[4:3]] >> {pos_q[2:0], 3'b000};
		rsum = xxh_pkg::rotl(lane_q[0], 1) + xxh_pkg::rotl(lane_q[1], 7)
			+ xxh_pkg::rotl(lane_q[2], 12) + xxh_pkg::rotl(lane_q[3], 18);
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			xxh_pkg::ST_LR1: begin
				ma = buf_q[cmd.idx];
				mb = xxh_pkg::P2;
			end
			xxh_pkg::ST_MG1: begin
				ma = lane_q[cmd.idx];
				mb = xxh_pkg::P2;
			end
			xxh_pkg::ST_T81: begin
				ma = buf_q[pos_q[4:3]];
				mb = xxh_pkg::P2;
			end
			xxh_pkg::ST_LR2, xxh_pkg::ST_MG2, xxh_pkg::ST_MG3, xxh_pkg::ST_T82,
			xxh_pkg::ST_T83, xxh_pkg::ST_T12: begin
				ma = t_q;
				mb = xxh_pkg::P1;
			end
			xxh_pkg::ST_T41: begin
				ma = {32'd0, tw[31:0]};
				mb = xxh_pkg::P1;
			end
			xxh_pkg::ST_T42: begin
				ma = t_q;
				mb = xxh_pkg::P2;
			end
			xxh_pkg::ST_T11: begin
				ma = {56'd0, tw[7:0]};
				mb = xxh_pkg::P5;
			end
			xxh_pkg::ST_AV1: begin
				ma = h_q ^ (h_q >> 33);
				mb = xxh_pkg::P2;
			end
			xxh_pkg::ST_AV2: begin
				ma = h_q ^ (h_q >> 29);
				mb = xxh_pkg::P3;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	xxh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.a      (ma),
		.b      (mb),
		.done   (mul_done),
		.p      (p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			len_q  <= '0;
			fill_q <= '0;
			pos_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_data;
			end
			if (cmd.load) begin
				fill_q <= fill_sum[4:0];
				len_q  <= len_q + {60'd0, cnt};
			end
			if (cmd.wb) begin
				case (cmd.op)
					xxh_pkg::ST_LR2: begin
						if (cmd.idx == 2'd3) begin
							done_q <= 1'b1;
						end
					end
					xxh_pkg::ST_HINIT: pos_q <= '0;
					xxh_pkg::ST_T83:   pos_q <= pos_q + 5'd8;
					xxh_pkg::ST_T42:   pos_q <= pos_q + 5'd4;
					xxh_pkg::ST_T12:   pos_q <= pos_q + 5'd1;
					xxh_pkg::ST_FIN: begin
						fill_q <= '0;
						len_q  <= '0;
						done_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && cnt != 4'd0) begin
			buf_q[fill_q[4:3]] <= wordm;
		end
		if (cmd.wb) begin
			case (cmd.op)
				xxh_pkg::ST_LR1:    t_q <= xxh_pkg::rotl(lsrc + p, 31);
				xxh_pkg::ST_LR2:    lane_q[cmd.idx] <= p;
				xxh_pkg::ST_HINIT:  h_q <= done_q ? rsum : seed_q + xxh_pkg::P5;
				xxh_pkg::ST_MG1:    t_q <= xxh_pkg::rotl(p, 31);
				xxh_pkg::ST_MG2:    t_q <= h_q ^ p;
				xxh_pkg::ST_MG3:    h_q <= p + xxh_pkg::P4;
				xxh_pkg::ST_ADDLEN: h_q <= h_q + len_q;
				xxh_pkg::ST_T81:    t_q <= xxh_pkg::rotl(p, 31);
				xxh_pkg::ST_T82:    t_q <= xxh_pkg::rotl(h_q ^ p, 27);
				xxh_pkg::ST_T83:    h_q <= p + xxh_pkg::P4;
				xxh_pkg::ST_T41:    t_q <= xxh_pkg::rotl(h_q ^ p, 23);
				xxh_pkg::ST_T42:    h_q <= p + xxh_pkg::P3;
				xxh_pkg::ST_T11:    t_q <= xxh_pkg::rotl(h_q ^ p, 11);
				xxh_pkg::ST_T12:    h_q <= p;
				xxh_pkg::ST_AV1:    h_q <= p;
				xxh_pkg::ST_AV2:    h_q <= p;
				xxh_pkg::ST_FIN:    dig_q <= h_q ^ (h_q >> 32);
				default: ;
			endcase
		end
	end

	always_comb begin
		sts.fold_need   = fill_sum[5];
		sts.stripe_done = done_q;
		sts.t8          = ({1'b0, pos_q} + 6'd8) <= {1'b0, fill_q};
		sts.t4          = ({1'b0, pos_q} + 6'd4) <= {1'b0, fill_q};
		sts.t1          = pos_q < fill_q;
		sts.mul_done    = mul_done;
	end

	assign digest = dig_q;

endmodule

[sv/xxh_ctrl.sv]
// ----------------------------------------------------------------------------
// xxh_ctrl
// Sequencer: accepts words, steps stripe folds, merge, tail and avalanche.
// ----------------------------------------------------------------------------
module xxh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_word,
	input  logic          out_stall,
	input  xxh_pkg::sts_t sts,
	output xxh_pkg::cmd_t cmd,
	output logic          in_stall,
	output logic          out_valid
);

	xxh_pkg::step_t st_q, st_n;
	logic [1:0] idx_q, idx_n;
	logic       iss_q, iss_n, last_q, last_n, ov_q, ov_n;
	logic       mul_st, fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= xxh_pkg::ST_IDLE;
			idx_q  <= '0;
			iss_q  <= 1'b0;
			last_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			st_q   <= st_n;
			idx_q  <= idx_n;
			iss_q  <= iss_n;
			last_q <= last_n;
			ov_q   <= ov_n;
		end
	end

	always_comb begin
		mul_st = st_q inside {xxh_pkg::ST_LR1, xxh_pkg::ST_LR2, xxh_pkg::ST_MG1,
			xxh_pkg::ST_MG2, xxh_pkg::ST_MG3, xxh_pkg::ST_T81, xxh_pkg::ST_T82,
			xxh_pkg::ST_T83, xxh_pkg::ST_T41, xxh_pkg::ST_T42, xxh_pkg::ST_T11,
			xxh_pkg::ST_T12, xxh_pkg::ST_AV1, xxh_pkg::ST_AV2};
		fire      = mul_st && iss_q && sts.mul_done;
		st_n      = st_q;
		idx_n     = idx_q;
		last_n    = last_q;
		iss_n     = iss_q;
		ov_n      = ov_q && out_stall;
		in_stall  = (st_q != xxh_pkg::ST_IDLE);
		cmd.op    = st_q;
		cmd.idx   = idx_q;
		cmd.load  = 1'b0;
		cmd.start = mul_st && !iss_q;
		cmd.wb    = fire;
		if (cmd.start) begin
			iss_n = 1'b1;
		end
		if (fire) begin
			iss_n = 1'b0;
		end
		case (st_q)
			xxh_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					last_n   = last_word;
					idx_n    = '0;
					if (sts.fold_need) begin
						st_n = xxh_pkg::ST_LR1;
					end else if (last_word) begin
						st_n = xxh_pkg::ST_HINIT;
					end
				end
			end
			xxh_pkg::ST_LR1: if (fire) st_n = xxh_pkg::ST_LR2;
			xxh_pkg::ST_LR2: begin
				if (fire) begin
					idx_n = idx_q + 2'd1;
					if (idx_q != 2'd3) begin
						st_n = xxh_pkg::ST_LR1;
					end else if (last_q) begin
						st_n = xxh_pkg::ST_HINIT;
					end else begin
						st_n = xxh_pkg::ST_IDLE;
					end
				end
			end
			xxh_pkg::ST_HINIT: begin
				cmd.wb = 1'b1;
				idx_n  = '0;
				st_n   = sts.stripe_done ? xxh_pkg::ST_MG1 : xxh_pkg::ST_ADDLEN;
			end
			xxh_pkg::ST_MG1: if (fire) st_n = xxh_pkg::ST_MG2;
			xxh_pkg::ST_MG2: if (fire) st_n = xxh_pkg::ST_MG3;
			xxh_pkg::ST_MG3: begin
				if (fire) begin
					idx_n = idx_q + 2'd1;
					st_n  = (idx_q == 2'd3) ? xxh_pkg::ST_ADDLEN : xxh_pkg::ST_MG1;
				end
			end
			xxh_pkg::ST_ADDLEN: begin
				cmd.wb = 1'b1;
				st_n   = xxh_pkg::ST_TAIL;
			end
			xxh_pkg::ST_TAIL: begin
				if (sts.t8) begin
					st_n = xxh_pkg::ST_T81;
				end else if (sts.t4) begin
					st_n = xxh_pkg::ST_T41;
				end else if (sts.t1) begin
					st_n = xxh_pkg::ST_T11;
				end else begin
					st_n = xxh_pkg::ST_AV1;
				end
			end
			xxh_pkg::ST_T81: if (fire) st_n = xxh_pkg::ST_T82;
			xxh_pkg::ST_T82: if (fire) st_n = xxh_pkg::ST_T83;
			xxh_pkg::ST_T83: if (fire) st_n = xxh_pkg::ST_TAIL;
			xxh_pkg::ST_T41: if (fire) st_n = xxh_pkg::ST_T42;
			xxh_pkg::ST_T42: if (fire) st_n = xxh_pkg::ST_TAIL;
			xxh_pkg::ST_T11: if (fire) st_n = xxh_pkg::ST_T12;
			xxh_pkg::ST_T12: if (fire) st_n = xxh_pkg::ST_TAIL;
			xxh_pkg::ST_AV1: if (fire) st_n = xxh_pkg::ST_AV2;
			xxh_pkg::ST_AV2: if (fire) st_n = xxh_pkg::ST_FIN;
			xxh_pkg::ST_FIN: begin
				if (!ov_q || !out_stall) begin
					cmd.wb = 1'b1;
					ov_n   = 1'b1;
					st_n   = xxh_pkg::ST_IDLE;
				end
			end
			default: st_n = xxh_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = ov_q;

endmodule

[sv/xxh_checker.sv]
// ----------------------------------------------------------------------------
// xxh_checker
// Port-level checks of the XXH64 digest block, bound to the top level.
// ----------------------------------------------------------------------------
`include "xxhash64_digest_defines.svh"

module xxh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_word,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] digest
);

	`XXH_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(digest))
	`XXH_ASSERT_NXT(a_no_spurious, clk, arst_n, in_valid && !in_stall && !last_word, !$rose(out_valid))
	`XXH_ASSERT_NXT(a_busy_last, clk, arst_n, in_valid && !in_stall && last_word, in_stall)

endmodule

bind xxhash64_digest xxh_checker u_xxh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last_word (last_word),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.digest    (digest)
);

[verif/tb_xxhash64_digest.sv]
// ----------------------------------------------------------------------------
// tb_xxhash64_digest
// Drives whole messages into the XXH64 digest block with random idling on
// both channels, predicts each digest in the bench and compares it with the
// block's output. Covers seed settings, partial and oversized counts, empty
// messages, stripe boundaries, and long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_xxhash64_digest;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last_word;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] digest;

	logic [63:0] seed_q;
	logic [63:0] lanes[4];
	logic [63:0] stripe[4];
	int unsigned fill;
	logic [63:0] msg_len;
	logic        folded;

	logic [63:0] digest_queue[$];
	int          fail_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          recv_hold;
	int          quiet_cycles;

	xxhash64_digest uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .data_word(data_word),
		.byte_count(byte_count), .last_word(last_word), .out_valid(out_valid),
		.out_stall(out_stall), .digest(digest)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [63:0] rot64(logic [63:0] x, int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] mix_round(logic [63:0] acc, logic [63:0] w);
		acc = acc + w * xxh_pkg::P2;
		return rot64(acc, 31) * xxh_pkg::P1;
	endfunction

	task automatic load_lanes();
		lanes[0] = seed_q + xxh_pkg::P1 + xxh_pkg::P2;
		lanes[1] = seed_q + xxh_pkg::P2;
		lanes[2] = seed_q;
		lanes[3] = seed_q - xxh_pkg::P1;
	endtask

	task automatic clear_message();
		load_lanes();
		foreach (stripe[i]) stripe[i] = '0;
		fill = 0;
		msg_len = '0;
		folded = 1'b0;
	endtask

	function automatic logic [63:0] finish_digest();
		logic [63:0] h;
		logic [63:0] w;
		int unsigned pos;
		pos = 0;
		if (folded) begin
			h = rot64(lanes[0], 1) + rot64(lanes[1], 7) + rot64(lanes[2], 12)
				+ rot64(lanes[3], 18);
			for (int i = 0; i < 4; i++) begin
				h = h ^ mix_round(64'd0, lanes[i]);
				h = h * xxh_pkg::P1 + xxh_pkg::P4;
			end
		end else begin
			h = seed_q + xxh_pkg::P5;
		end
		h = h + msg_len;
		while (pos + 8 <= fill) begin
			h = h ^ mix_round(64'd0, stripe[pos >> 3]);
			h = rot64(h, 27) * xxh_pkg::P1 + xxh_pkg::P4;
			pos += 8;
		end
		if (pos + 4 <= fill) begin
			w = stripe[pos >> 3] >> ((pos & 7) * 8);
			h = h ^ ((w & 64'hFFFF_FFFF) * xxh_pkg::P1);
			h = rot64(h, 23) * xxh_pkg::P2 + xxh_pkg::P3;
			pos += 4;
		end
		while (pos < fill) begin
			w = stripe[pos >> 3] >> ((pos & 7) * 8);
			h = h ^ ((w & 64'hFF) * xxh_pkg::P5);
			h = rot64(h, 11) * xxh_pkg::P1;
			pos++;
		end
		h = h ^ (h >> 33);
		h = h * xxh_pkg::P2;
		h = h ^ (h >> 29);
		h = h * xxh_pkg::P3;
		return h ^ (h >> 32);
	endfunction

	task automatic predict_word(logic [63:0] w, logic [3:0] cnt, logic lst);
		int unsigned c;
		c = cnt;
		if (!lst || c > 8) c = 8;
		if (c == 0) w = '0;
		else if (c < 8) w = w & ((64'd1 << (c * 8)) - 1);
		if (c > 0) begin
			stripe[(fill >> 3) & 3] = w;
			fill += c;
		end
		msg_len = msg_len + c;
		if (fill >= 32) begin
			if (!folded) load_lanes();
			for (int i = 0; i < 4; i++) lanes[i] = mix_round(lanes[i], stripe[i]);
			folded = 1'b1;
			fill = 0;
		end
		if (lst) begin
			digest_queue = {digest_queue, finish_digest()};
			clear_message();
		end
	endtask

	task automatic send_word(logic [63:0] w, logic [3:0] cnt, logic lst);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_word <= w;
		byte_count <= cnt;
		last_word <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_word(w, cnt, lst);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (digest_queue.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_seed(logic [63:0] s);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= s;
		@(negedge clk);
		cfg_we <= 1'b0;
		seed_q = s;
		clear_message();
	endtask

	task automatic send_message(int words, bit odd_counts);
		logic [3:0] cnt;
		for (int i = 0; i < words; i++) begin
			cnt = (i == words - 1) ? 4'($urandom_range(8, 0)) : 4'd8;
			if (odd_counts) cnt = 4'($urandom_range(15, 0));
			send_word({$urandom, $urandom}, cnt, i == words - 1);
		end
	endtask

	task automatic test_directed();
		send_word(64'd0, 4'd0, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
		send_word(64'h0123_4567_89AB_CDEF, 4'd4, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
		send_word(64'hA5A5_A5A5_A5A5_A5A5, 4'd9, 1'b1);
		send_word(64'h5A5A_5A5A_5A5A_5A5A, 4'd3, 1'b0);
		send_word(64'h1111_2222_3333_4444, 4'd0, 1'b0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1);
		for (int i = 0; i < 4; i++) send_word({$urandom, $urandom}, 4'd8, i == 3);
		for (int i = 0; i < 5; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
		send_word(64'hDEAD_BEEF_0BAD_F00D, 4'd5, 1'b1);
	endtask

	task automatic test_seeds();
		logic [63:0] seeds[3];
		seeds = '{64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom}, 64'd0};
		foreach (seeds[k]) begin
			write_seed(seeds[k]);
			send_word(64'd0, 4'd0, 1'b1);
			send_message(6, 1'b0);
			send_message(2, 1'b0);
		end
	endtask

	task automatic test_random(int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
			send_message(n, $urandom_range(4, 0) == 0);
			sent += n;
		end
	endtask

	task automatic test_backpressure();
		recv_hold = 1'b1;
		for (int i = 0; i < 12; i++) send_word({$urandom, $urandom}, 4'd8, 1'(i % 2));
		wait_drained();
		send_message(5, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		data_word = '0;
		byte_count = '0;
		last_word = 1'b0;
		fail_count = 0;
		send_idle_pct = 38;
		recv_idle_pct = 54;
		recv_hold = 1'b0;
		seed_q = '0;
		clear_message();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_seeds();
		test_random(110);
		send_idle_pct = 54;
		recv_idle_pct = 38;
		test_backpressure();
		test_random(110);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_seed({$urandom, $urandom});
		test_random(110);
		wait_drained();
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		out_stall = 1'b1;
		forever begin
			@(negedge clk);
			if (recv_hold) begin
				out_stall <= 1'b1;
				repeat (3000) @(negedge clk);
				recv_hold = 1'b0;
			end
			out_stall <= !arst_n || ($urandom_range(99, 0) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (digest_queue.size() == 0) begin
				$error("digest with no message pending: %h", digest);
				fail_count++;
			end else begin
				if (digest !== digest_queue[0]) begin
					$error("digest expected %h actual %h", digest_queue[0], digest);
					fail_count++;
				end
				void'(digest_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || recv_hold
			|| (digest_queue.size() == 0 && !in_valid))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

[sim.f]
+incdir+sv
sv/xxh_pkg.sv
sv/xxh_mul.sv
sv/xxh_dp.sv
sv/xxh_ctrl.sv
sv/xxhash64_digest.sv
sv/xxh_checker.sv
verif/tb_xxhash64_digest.sv
